@@ src/hmrr_pkg.sv @@
// Package for the hyperbolic Mobius random-rotate block: widths, register
// indexes, the CORDIC arctangent table and the structs passed between cells.
// No dependencies.
package hmrr_pkg;

	// Coordinate format and saturation range (signed Q8.24).
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS = 24;
	localparam int SHIFT_W = 31;
	localparam int STEP_W = 15;
	localparam int RAND_W = 16;

	// Intermediate widths of the Mobius and rotation datapath.
	localparam int CD_W = 40;
	localparam int DEN_W = 80;
	localparam int U_W = 74;
	localparam int TRIG_W = 32;
	localparam int Z_W = 34;
	localparam int ROT_W = 77;
	localparam int NUM_W = 108;
	localparam int Q_W = 62;

	// Multiplier slice width.
	localparam int CHUNK_W = 32;

	// CORDIC set-up.
	localparam int CORDIC_STEPS = 30;
	localparam int TRIG_FRAC = 30;
	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;
	localparam logic [29:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
		30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
		30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
		30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
	};

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd2;

	// One CORDIC cell's working set.
	typedef struct packed {
		logic signed [Z_W-1:0] z;
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic flip;
	} cordic_t;

	// One divider cell's working set; both axes share the denominator.
	typedef struct packed {
		logic [NUM_W-1:0] rem_x;
		logic [NUM_W-1:0] rem_y;
		logic [Q_W-1:0] q_x;
		logic [Q_W-1:0] q_y;
		logic [DEN_W-1:0] den;
		logic neg_x;
		logic neg_y;
		logic huge_x;
		logic huge_y;
		logic den_zero;
	} quot_t;

endpackage

@@ src/hmrr_mul.sv @@
// Two-stage signed multiplier built from registered 33x33 slice products.
// Depends on hmrr_pkg for the slice width.
module hmrr_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic clk,
	input  logic ce,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output logic signed [WA+WB-1:0] p
);
	import hmrr_pkg::*;

	localparam int NA = (WA + CHUNK_W - 1) / CHUNK_W;
	localparam int NB = (WB + CHUNK_W - 1) / CHUNK_W;
	localparam int PW = WA + WB;
	localparam int SW = (NA + NB) * CHUNK_W + 2;
	localparam int PPW = 2 * CHUNK_W + 2;

	logic signed [NA*CHUNK_W-1:0] ax;
	logic signed [NB*CHUNK_W-1:0] bx;
	logic signed [PPW-1:0] pp_s1 [NA*NB];
	logic signed [SW-1:0] total;
	logic signed [PW-1:0] prod_s2;

	assign ax = (NA*CHUNK_W)'(a);
	assign bx = (NB*CHUNK_W)'(b);

	// Slice products: the top slice of each operand is signed, the others unsigned.
	for (genvar i = 0; i < NA; i++) begin : g_a
		for (genvar j = 0; j < NB; j++) begin : g_b
			logic signed [CHUNK_W:0] ca;
			logic signed [CHUNK_W:0] cb;
			assign ca = (i == NA-1) ? {ax[NA*CHUNK_W-1], ax[i*CHUNK_W +: CHUNK_W]}
				: {1'b0, ax[i*CHUNK_W +: CHUNK_W]};
			assign cb = (j == NB-1) ? {bx[NB*CHUNK_W-1], bx[j*CHUNK_W +: CHUNK_W]}
				: {1'b0, bx[j*CHUNK_W +: CHUNK_W]};
			always_ff @(posedge clk) begin
				if (ce) begin
					pp_s1[i*NB+j] <= ca * cb;
				end
			end
		end
	end

	// Weighted sum of the slice products.
	always_comb begin
		total = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				total = total + (SW'(pp_s1[i*NB+j]) <<< (CHUNK_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s2 <= total[PW-1:0];
		end
	end

	assign p = prod_s2;

endmodule

@@ src/hmrr_cordic_cell.sv @@
// One micro-rotation of the sine/cosine CORDIC chain, with its output register.
// Depends on hmrr_pkg for cordic_t and the arctangent table.
module hmrr_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic ce,
	input  hmrr_pkg::cordic_t din,
	output hmrr_pkg::cordic_t dout
);
	import hmrr_pkg::*;

	localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TURN[IDX]);

	logic signed [TRIG_W-1:0] dx;
	logic signed [TRIG_W-1:0] dy;
	cordic_t nxt;
	cordic_t cell_q;

	// Rotate toward zero residual angle.
	always_comb begin
		dx = din.y >>> IDX;
		dy = din.x >>> IDX;
		nxt.flip = din.flip;
		if (!din.z[Z_W-1]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ANG;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

@@ src/hmrr_div_cell.sv @@
// One restoring-division step for both axes: settles one quotient bit.
// Depends on hmrr_pkg for quot_t and the widths.
module hmrr_div_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic ce,
	input  hmrr_pkg::quot_t din,
	output hmrr_pkg::quot_t dout
);
	import hmrr_pkg::*;

	logic [NUM_W-1:0] den_w;
	logic [NUM_W-1:0] den_sh;
	logic ge_x;
	logic ge_y;
	quot_t nxt;
	quot_t cell_q;

	// Subtract the shifted denominator where it fits in the remainder.
	always_comb begin
		den_w = NUM_W'(din.den);
		den_sh = den_w << IDX;
		ge_x = (din.rem_x >> IDX) >= den_w;
		ge_y = (din.rem_y >> IDX) >= den_w;
		nxt = din;
		if (ge_x) begin
			nxt.rem_x = din.rem_x - den_sh;
		end
		if (ge_y) begin
			nxt.rem_y = din.rem_y - den_sh;
		end
		nxt.q_x[IDX] = ge_x;
		nxt.q_y[IDX] = ge_y;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

@@ src/hyperbolic_mobius_random_rotate.sv @@
// Top level of the hyperbolic Mobius random-rotate block.
// Depends on hmrr_pkg, hmrr_mul, hmrr_cordic_cell and hmrr_div_cell.
//
// Usage: a request on the s_ channel carries one point, a random fraction
// and the accumulator pair; the m_ channel returns the accumulator plus the
// rotated Mobius contribution, with the saturation flag in m_tuser.
// The configuration port writes tile_shift, angle_step and weight; write it
// only while no request is in flight.
// Path: a request accepted on s_ passes through the 30-cell CORDIC chain,
// which runs beside the Mobius products, then the rotation and weight
// multipliers and the 62-cell quotient chain before m_tvalid rises.
// Throughput is one request per cycle while the receiver takes results.
// Reset clears the pipeline valid bits and loads the registers with their
// defaults (shift 1.0, step 21845, weight 1.0).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and a one-entry input buffer takes one more request before s_tready drops.
module hyperbolic_mobius_random_rotate (
	input  logic clk,
	input  logic arst_n,
	// s_tdata: in_x[31:0], in_y[63:32], random_fraction[79:64],
	// acc_x[111:80], acc_y[143:112]
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [143:0] s_tdata,
	// m_tdata: sum_x[31:0], sum_y[63:32]; m_tuser: saturated
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata,
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [hmrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmrr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hmrr_pkg::*;

	localparam int ST_DIV = 40;
	localparam int ST_LAST = ST_DIV + Q_W + 1;
	localparam logic signed [63:0] C_ROUND = 64'sd1 <<< (2 * FRAC_BITS);
	localparam logic signed [63:0] SUM_HI = (64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1;
	localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;

	typedef struct packed {
		logic signed [U_W-1:0] ux;
		logic signed [U_W-1:0] uy;
		logic [DEN_W-1:0] den;
	} rot_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] val;
		logic sat;
	} clip_t;

	// Adds the signed quotient to the accumulator and clamps it.
	function automatic clip_t clamp_sum(input logic signed [COORD_WIDTH-1:0] acc,
		input logic [Q_W-1:0] q, input logic neg, input logic huge);
		logic signed [Q_W:0] qs;
		logic signed [63:0] s;
		clip_t r;
		qs = $signed({1'b0, q});
		if (neg) begin
			qs = -qs;
		end
		s = 64'(acc) + 64'(qs);
		r.sat = 1'b1;
		if (huge) begin
			r.val = neg ? COORD_WIDTH'(SUM_LO) : COORD_WIDTH'(SUM_HI);
		end else if (s > SUM_HI) begin
			r.val = COORD_WIDTH'(SUM_HI);
		end else if (s < SUM_LO) begin
			r.val = COORD_WIDTH'(SUM_LO);
		end else begin
			r.val = COORD_WIDTH'(s);
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// Configuration registers.
	logic [SHIFT_W-1:0] tile_shift_q;
	logic [STEP_W-1:0] angle_step_q;
	logic signed [COORD_WIDTH-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q <= 31'd16777216;
			angle_step_q <= 15'd21845;
			weight_q <= 32'sd16777216;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_SHIFT: tile_shift_q <= cfg_data[SHIFT_W-1:0];
				REG_ANGLE_STEP: angle_step_q <= cfg_data[STEP_W-1:0];
				REG_WEIGHT: weight_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Handshake: the pipeline advances unless a result waits unaccepted.
	logic ce;
	logic skid_vld_q;
	logic [143:0] skid_q;
	logic hd_valid;
	logic [143:0] hd_data;
	logic [ST_LAST:1] vld_q;

	assign ce = !vld_q[ST_LAST] || m_tready;
	assign s_tready = !skid_vld_q;
	assign hd_valid = skid_vld_q || s_tvalid;
	assign hd_data = skid_vld_q ? skid_q : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
			vld_q <= '0;
		end else begin
			if (ce) begin
				skid_vld_q <= 1'b0;
				vld_q <= {vld_q[ST_LAST-1:1], hd_valid};
			end else if (s_tvalid && s_tready) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ce && s_tvalid && s_tready) begin
			skid_q <= s_tdata;
		end
	end

	// Input stage and the accumulator delay line.
	logic signed [COORD_WIDTH-1:0] x_s1;
	logic signed [COORD_WIDTH-1:0] y_s1;
	logic [RAND_W-1:0] f_s1;
	logic [2*COORD_WIDTH-1:0] acc_q [1:ST_DIV+Q_W];

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s1 <= $signed(hd_data[31:0]);
			y_s1 <= $signed(hd_data[63:32]);
			f_s1 <= hd_data[79:64];
			acc_q[1] <= hd_data[143:80];
			for (int k = 2; k <= ST_DIV + Q_W; k++) begin
				acc_q[k] <= acc_q[k-1];
			end
		end
	end

	// Mobius numerator terms: a = x + r, b = y, c = r*x + 1, d = r*y.
	logic signed [COORD_WIDTH:0] a_s2;
	logic signed [COORD_WIDTH:0] a_s3;
	logic signed [COORD_WIDTH:0] a_s4;
	logic signed [COORD_WIDTH-1:0] y_s2;
	logic signed [COORD_WIDTH-1:0] y_s3;
	logic signed [COORD_WIDTH-1:0] b_s4;
	logic signed [63:0] rxp_s3;
	logic signed [63:0] ryp_s3;
	logic signed [CD_W-1:0] c_s4;
	logic signed [CD_W-1:0] d_s4;
	logic signed [COORD_WIDTH-1:0] r_sg;

	assign r_sg = $signed({1'b0, tile_shift_q});

	hmrr_mul #(.WA(COORD_WIDTH), .WB(COORD_WIDTH)) u_mul_rx (
		.clk(clk), .ce(ce), .a(x_s1), .b(r_sg), .p(rxp_s3));
	hmrr_mul #(.WA(COORD_WIDTH), .WB(COORD_WIDTH)) u_mul_ry (
		.clk(clk), .ce(ce), .a(y_s1), .b(r_sg), .p(ryp_s3));

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s2 <= (COORD_WIDTH+1)'(x_s1) + $signed({2'b00, tile_shift_q});
			a_s3 <= a_s2;
			a_s4 <= a_s3;
			y_s2 <= y_s1;
			y_s3 <= y_s2;
			b_s4 <= y_s3;
			c_s4 <= CD_W'((rxp_s3 + C_ROUND) >>> FRAC_BITS);
			d_s4 <= CD_W'(ryp_s3 >>> FRAC_BITS);
		end
	end

	// Denominator and unrotated numerator.
	logic signed [2*CD_W-1:0] cc_s6;
	logic signed [2*CD_W-1:0] dd_s6;
	logic signed [CD_W+COORD_WIDTH:0] ac_s6;
	logic signed [CD_W+COORD_WIDTH:0] ad_s6;
	logic signed [CD_W+COORD_WIDTH-1:0] bd_s6;
	logic signed [CD_W+COORD_WIDTH-1:0] bc_s6;
	rot_t rot_q [7:ST_DIV-1];

	hmrr_mul #(.WA(CD_W), .WB(CD_W)) u_mul_cc (
		.clk(clk), .ce(ce), .a(c_s4), .b(c_s4), .p(cc_s6));
	hmrr_mul #(.WA(CD_W), .WB(CD_W)) u_mul_dd (
		.clk(clk), .ce(ce), .a(d_s4), .b(d_s4), .p(dd_s6));
	hmrr_mul #(.WA(CD_W), .WB(COORD_WIDTH+1)) u_mul_ac (
		.clk(clk), .ce(ce), .a(c_s4), .b(a_s4), .p(ac_s6));
	hmrr_mul #(.WA(CD_W), .WB(COORD_WIDTH+1)) u_mul_ad (
		.clk(clk), .ce(ce), .a(d_s4), .b(a_s4), .p(ad_s6));
	hmrr_mul #(.WA(CD_W), .WB(COORD_WIDTH)) u_mul_bd (
		.clk(clk), .ce(ce), .a(d_s4), .b(b_s4), .p(bd_s6));
	hmrr_mul #(.WA(CD_W), .WB(COORD_WIDTH)) u_mul_bc (
		.clk(clk), .ce(ce), .a(c_s4), .b(b_s4), .p(bc_s6));

	always_ff @(posedge clk) begin
		if (ce) begin
			rot_q[7].den <= DEN_W'($unsigned(cc_s6)) + DEN_W'($unsigned(dd_s6));
			rot_q[7].ux <= U_W'(ac_s6) + U_W'(bd_s6);
			rot_q[7].uy <= U_W'(bc_s6) - U_W'(ad_s6);
			for (int k = 8; k <= ST_DIV - 1; k++) begin
				rot_q[k] <= rot_q[k-1];
			end
		end
	end

	// Angle and CORDIC: fold into a half turn, then the micro-rotation cells.
	logic [TRIG_W-1:0] theta_s2;
	logic [TRIG_W-1:0] t_add;
	logic [TRIG_W-1:0] t_fold;
	logic flip;
	cordic_t fold_s3;
	cordic_t cq [0:CORDIC_STEPS];
	logic signed [TRIG_W-1:0] cs_s34;
	logic signed [TRIG_W-1:0] sn_s34;

	always_comb begin
		t_add = theta_s2 + 32'h4000_0000;
		flip = t_add[TRIG_W-1];
		t_fold = flip ? theta_s2 + 32'h8000_0000 : theta_s2;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			theta_s2 <= 32'(f_s1) * 32'(angle_step_q);
			fold_s3.z <= Z_W'($signed(t_fold));
			fold_s3.x <= CORDIC_X0;
			fold_s3.y <= '0;
			fold_s3.flip <= flip;
		end
	end

	assign cq[0] = fold_s3;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		hmrr_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk), .ce(ce), .din(cq[i]), .dout(cq[i+1]));
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cs_s34 <= cq[CORDIC_STEPS].flip ? -cq[CORDIC_STEPS].x : cq[CORDIC_STEPS].x;
			sn_s34 <= cq[CORDIC_STEPS].flip ? -cq[CORDIC_STEPS].y : cq[CORDIC_STEPS].y;
		end
	end

	// Rotation by (cs, sn).
	logic signed [U_W+TRIG_W-1:0] uxcs_s36;
	logic signed [U_W+TRIG_W-1:0] uysn_s36;
	logic signed [U_W+TRIG_W-1:0] uycs_s36;
	logic signed [U_W+TRIG_W-1:0] uxsn_s36;
	logic signed [U_W+TRIG_W:0] rsum_x;
	logic signed [U_W+TRIG_W:0] rsum_y;
	logic signed [ROT_W-1:0] rx_s37;
	logic signed [ROT_W-1:0] ry_s37;

	hmrr_mul #(.WA(U_W), .WB(TRIG_W)) u_mul_uxcs (
		.clk(clk), .ce(ce), .a(rot_q[34].ux), .b(cs_s34), .p(uxcs_s36));
	hmrr_mul #(.WA(U_W), .WB(TRIG_W)) u_mul_uysn (
		.clk(clk), .ce(ce), .a(rot_q[34].uy), .b(sn_s34), .p(uysn_s36));
	hmrr_mul #(.WA(U_W), .WB(TRIG_W)) u_mul_uycs (
		.clk(clk), .ce(ce), .a(rot_q[34].uy), .b(cs_s34), .p(uycs_s36));
	hmrr_mul #(.WA(U_W), .WB(TRIG_W)) u_mul_uxsn (
		.clk(clk), .ce(ce), .a(rot_q[34].ux), .b(sn_s34), .p(uxsn_s36));

	always_comb begin
		rsum_x = (U_W+TRIG_W+1)'(uxcs_s36) + (U_W+TRIG_W+1)'(uysn_s36);
		rsum_y = (U_W+TRIG_W+1)'(uycs_s36) - (U_W+TRIG_W+1)'(uxsn_s36);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rx_s37 <= rsum_x[U_W+TRIG_W:TRIG_FRAC];
			ry_s37 <= rsum_y[U_W+TRIG_W:TRIG_FRAC];
		end
	end

	// Weight products, then signs, magnitudes and the quotient range check.
	logic signed [ROT_W+COORD_WIDTH-1:0] px_s39;
	logic signed [ROT_W+COORD_WIDTH-1:0] py_s39;
	logic [NUM_W-1:0] mag_x;
	logic [NUM_W-1:0] mag_y;
	quot_t div_s40;
	quot_t dq [0:Q_W];

	hmrr_mul #(.WA(ROT_W), .WB(COORD_WIDTH)) u_mul_wx (
		.clk(clk), .ce(ce), .a(rx_s37), .b(weight_q), .p(px_s39));
	hmrr_mul #(.WA(ROT_W), .WB(COORD_WIDTH)) u_mul_wy (
		.clk(clk), .ce(ce), .a(ry_s37), .b(weight_q), .p(py_s39));

	always_comb begin
		mag_x = px_s39[ROT_W+COORD_WIDTH-1] ? NUM_W'(-px_s39) : NUM_W'(px_s39);
		mag_y = py_s39[ROT_W+COORD_WIDTH-1] ? NUM_W'(-py_s39) : NUM_W'(py_s39);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			div_s40.rem_x <= mag_x;
			div_s40.rem_y <= mag_y;
			div_s40.q_x <= '0;
			div_s40.q_y <= '0;
			div_s40.den <= rot_q[ST_DIV-1].den;
			div_s40.neg_x <= px_s39[ROT_W+COORD_WIDTH-1];
			div_s40.neg_y <= py_s39[ROT_W+COORD_WIDTH-1];
			div_s40.huge_x <= DEN_W'(mag_x >> Q_W) >= rot_q[ST_DIV-1].den;
			div_s40.huge_y <= DEN_W'(mag_y >> Q_W) >= rot_q[ST_DIV-1].den;
			div_s40.den_zero <= rot_q[ST_DIV-1].den == '0;
		end
	end

	assign dq[0] = div_s40;

	// Quotient chain, most significant bit first.
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		hmrr_div_cell #(.IDX(Q_W-1-k)) u_cell (
			.clk(clk), .ce(ce), .din(dq[k]), .dout(dq[k+1]));
	end

	// Accumulate, clamp and register the result.
	clip_t clip_x;
	clip_t clip_y;
	logic [63:0] m_tdata_q;
	logic m_tuser_q;

	always_comb begin
		clip_x = clamp_sum($signed(acc_q[ST_DIV+Q_W][COORD_WIDTH-1:0]), dq[Q_W].q_x,
			dq[Q_W].neg_x, dq[Q_W].huge_x);
		clip_y = clamp_sum($signed(acc_q[ST_DIV+Q_W][2*COORD_WIDTH-1:COORD_WIDTH]),
			dq[Q_W].q_y, dq[Q_W].neg_y, dq[Q_W].huge_y);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (dq[Q_W].den_zero) begin
				m_tdata_q <= {COORD_WIDTH'(SUM_HI), COORD_WIDTH'(SUM_HI)};
				m_tuser_q <= 1'b1;
			end else begin
				m_tdata_q <= {clip_y.val, clip_x.val};
				m_tuser_q <= clip_x.sat || clip_y.sat;
			end
		end
	end

	assign m_tvalid = vld_q[ST_LAST];
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

@@ sim/tb_hyperbolic_mobius_random_rotate.sv @@
// Self-checking testbench for hyperbolic_mobius_random_rotate: random and
// directed point requests against a bit-exact predictor of the Mobius map,
// the CORDIC rotation and the saturating sum. Depends on hmrr_pkg and the RTL.
module tb_hyperbolic_mobius_random_rotate;
	import hmrr_pkg::*;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic [15:0] frac;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
	} point_req_t;

	typedef struct {
		logic [31:0] sum_x;
		logic [31:0] sum_y;
		logic sat;
	} sum_res_t;

	// Index past the last register; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TILE_SHIFT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Copy of the configuration as the block should hold it.
	logic [30:0] shift_reg = 31'd16777216;
	logic [14:0] step_reg = 15'd21845;
	logic signed [31:0] weight_reg = 32'sd16777216;

	// When set, neither side inserts gaps or stalls.
	bit calm = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	hyperbolic_mobius_random_rotate u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Cosine and sine in Q2.30 of an angle in 2^-32 turn.
	function automatic void sincos(input logic [31:0] angle, output longint cs,
			output longint sn);
		logic [31:0] t;
		logic [31:0] probe;
		logic flip;
		longint z;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		t = angle;
		probe = t + 32'h40000000;
		flip = probe[31];
		if (flip) begin
			t = t + 32'h80000000;
		end
		z = longint'($signed(t));
		cx = 652032874;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - longint'(ATAN_TURN[i]);
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + longint'(ATAN_TURN[i]);
			end
		end
		cs = flip ? -cx : cx;
		sn = flip ? -cy : cy;
	endfunction

	// Weighted quotient added to the accumulator, with clipping.
	function automatic logic [31:0] weighted_sum(input wide_t num, input wide_t den,
			input logic signed [31:0] acc, inout logic sat);
		wide_t p;
		wide_t mag;
		wide_t q;
		wide_t s;
		logic neg;
		p = num * wide_t'(weight_reg);
		neg = p < 0;
		mag = neg ? -p : p;
		q = mag / den;
		if (q >= (256'sd1 <<< 62)) begin
			sat = 1'b1;
			return neg ? COORD_MIN[31:0] : COORD_MAX[31:0];
		end
		s = wide_t'(acc) + (neg ? -q : q);
		if (s > COORD_MAX) begin
			sat = 1'b1;
			return COORD_MAX[31:0];
		end
		if (s < COORD_MIN) begin
			sat = 1'b1;
			return COORD_MIN[31:0];
		end
		return s[31:0];
	endfunction

	// Full prediction of one request under the current configuration.
	function automatic sum_res_t mobius_rotate(input point_req_t req);
		sum_res_t res;
		wide_t r;
		wide_t xw;
		wide_t yw;
		wide_t a;
		wide_t c;
		wide_t d;
		wide_t den;
		wide_t ux;
		wide_t uy;
		wide_t csw;
		wide_t snw;
		wide_t rx;
		wide_t ry;
		longint cs;
		longint sn;
		logic [31:0] angle;
		logic sat;
		r = $signed({1'b0, shift_reg});
		xw = req.in_x;
		yw = req.in_y;
		a = xw + r;
		c = (r * xw + (256'sd1 <<< 48)) >>> 24;
		d = (r * yw) >>> 24;
		den = c * c + d * d;
		if (den == 0) begin
			res.sum_x = COORD_MAX[31:0];
			res.sum_y = COORD_MAX[31:0];
			res.sat = 1'b1;
			return res;
		end
		angle = 32'(req.frac) * 32'(step_reg);
		sincos(angle, cs, sn);
		csw = cs;
		snw = sn;
		ux = a * c + yw * d;
		uy = yw * c - a * d;
		rx = (ux * csw + uy * snw) >>> 30;
		ry = (uy * csw - ux * snw) >>> 30;
		sat = 1'b0;
		res.sum_x = weighted_sum(rx, den, req.acc_x, sat);
		res.sum_y = weighted_sum(ry, den, req.acc_y, sat);
		res.sat = sat;
		return res;
	endfunction

	class sum_board;
		sum_res_t pending[$];
		int errors = 0;

		function void note(point_req_t req);
			pending.push_back(mobius_rotate(req));
		endfunction

		function void check(logic [31:0] sx, logic [31:0] sy, logic sat);
			sum_res_t e;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: sum_x %h sum_y %h", sx, sy);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (sx !== e.sum_x) begin
				$error("sum_x expected %h actual %h", e.sum_x, sx);
				errors++;
			end
			if (sy !== e.sum_y) begin
				$error("sum_y expected %h actual %h", e.sum_y, sy);
				errors++;
			end
			if (sat !== e.sat) begin
				$error("saturated expected %b actual %b", e.sat, sat);
				errors++;
			end
		endfunction
	endclass

	sum_board board = new();

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// Register write; the model copy keeps only the implemented bits.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TILE_SHIFT: shift_reg = val[30:0];
			REG_ANGLE_STEP: step_reg = val[14:0];
			REG_WEIGHT: weight_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send(input point_req_t req);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {req.acc_y, req.acc_x, req.frac, req.in_y, req.in_x};
		do @(posedge clk); while (!s_tready);
		board.note(req);
	endtask

	// Stops sending and waits until every outstanding result has been checked.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	task automatic send_pt(input longint x, input longint y, input int f, input longint ax,
			input longint ay);
		point_req_t req;
		req.in_x = x[31:0];
		req.in_y = y[31:0];
		req.frac = f[15:0];
		req.acc_x = ax[31:0];
		req.acc_y = ay[31:0];
		send(req);
	endtask

	// Random request: full range, small points, near a zero denominator,
	// or with the accumulator near a bound.
	function automatic point_req_t random_req();
		point_req_t req;
		longint base;
		req.in_x = $urandom;
		req.in_y = $urandom;
		req.frac = 16'($urandom);
		req.acc_x = $urandom;
		req.acc_y = $urandom;
		case ($urandom_range(0, 5))
			0, 1: begin
				req.in_x = $signed(32'($urandom_range(0, 32'h0FFFFFFF))) - 32'sh08000000;
				req.in_y = $signed(32'($urandom_range(0, 32'h0FFFFFFF))) - 32'sh08000000;
				req.acc_x = $signed(32'($urandom_range(0, 32'h0FFFFFFF))) - 32'sh08000000;
				req.acc_y = $signed(32'($urandom_range(0, 32'h0FFFFFFF))) - 32'sh08000000;
			end
			2: begin
				if (shift_reg != 0) begin
					base = -((64'sd1 <<< 48) / longint'(shift_reg));
					req.in_x = 32'(base + longint'($urandom_range(0, 6)) - 3);
					req.in_y = 32'(longint'($urandom_range(0, 8)) - 4);
				end
			end
			3: begin
				req.acc_x = $urandom_range(0, 1) ? 32'sh7FFFFF00 + 32'($urandom_range(0, 255))
					: 32'sh80000000 + 32'($urandom_range(0, 255));
				req.acc_y = ~req.acc_x;
			end
			default: ;
		endcase
		return req;
	endfunction

	// Responder: random stall before each result, checked on acceptance.
	initial begin
		int stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check(m_tdata[31:0], m_tdata[63:32], m_tuser);
		end
	end

	// Stimulus: directed cases, then phases of random requests.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration, then with a maximal shift and weight and a negative weight.
		send_pt(0, 0, 0, 0, 0);
		send_pt(-16777216, 0, 1234, 0, 0);
		send_pt(-16777216, 0, 65535, 5, -5);
		send_pt(COORD_MAX, COORD_MAX, 65535, COORD_MAX, COORD_MAX);
		send_pt(COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN);
		send_pt(COORD_MAX, COORD_MIN, 32768, COORD_MIN, COORD_MAX);
		send_pt(16777216, 0, 16384, COORD_MAX, COORD_MIN);
		send_pt(-16777215, 0, 100, 0, 0);
		send_pt(-16777216, 1, 49152, 0, 0);
		send_pt(33554432, -33554432, 21845, COORD_MAX - 10, COORD_MIN + 10);
		send_pt(-1, -1, 65535, -1, -1);
		drain();
		write_reg(REG_TILE_SHIFT, 32'h7FFFFFFF);
		write_reg(REG_WEIGHT, 32'h7FFFFFFF);
		write_reg(REG_UNUSED, 32'h00000000);
		send_pt(-131072, 1, 7, 0, 0);
		send_pt(-131072, -1, 40000, 0, 0);
		send_pt(-131071, 0, 65535, 0, 0);
		drain();
		write_reg(REG_WEIGHT, 32'h80000000);
		send_pt(-131072, 1, 7, 0, 0);
		send_pt(-131073, 2, 30000, COORD_MAX, COORD_MIN);

		// Random phases, each under its own configuration.
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(REG_TILE_SHIFT, 32'd0);
					write_reg(REG_ANGLE_STEP, 32'd0);
					write_reg(REG_WEIGHT, 32'h80000000);
				end
				1: begin
					write_reg(REG_TILE_SHIFT, 32'hFFFFFFFF);
					write_reg(REG_ANGLE_STEP, 32'hFFFFFFFF);
					write_reg(REG_WEIGHT, 32'h7FFFFFFF);
				end
				2: begin
					write_reg(REG_TILE_SHIFT, 32'd16777216);
					write_reg(REG_ANGLE_STEP, 32'd21845);
					write_reg(REG_WEIGHT, 32'd0);
				end
				default: begin
					write_reg(REG_TILE_SHIFT, $urandom_range(0, 1) ? $urandom
						: 32'($urandom_range(0, 32'h04000000)));
					write_reg(REG_ANGLE_STEP, $urandom_range(0, 21845));
					write_reg(REG_WEIGHT, $urandom_range(0, 1) ? $urandom
						: 32'($urandom_range(0, 32'h04000000)) - 32'h02000000);
				end
			endcase
			calm = (ph == 3 || ph == 6);
			for (int n = 0; n < 200; n++) begin
				// Hold the sender once until the pipeline is empty.
				if (ph == 4 && n == 100) begin
					drain();
				end
				send(random_req());
			end
		end

		drain();
		repeat (120) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog on a hung handshake.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
